/* hw/rtl/trp_pkg.sv */
// Shared types, constants and status renumbering for the range result processor.
package trp_pkg;

  localparam int unsigned RATE_STEPS = 32;  // quotient bits of the per-SPAD rate divide
  localparam int unsigned SPAD_STEPS = 16;  // quotient bits of the SPAD request divide

  localparam logic [15:0] TARGET_RESET  = 16'd2560;
  localparam logic [10:0] GAIN_NUM      = 11'd2011;
  localparam logic [26:0] GAIN_ROUND    = 27'h0000400;
  localparam logic [15:0] RATE_CLIP     = 16'hFFFF;
  localparam logic [15:0] SPAD_FALLBACK = 16'h8000;

  // raw range status codes
  localparam logic [7:0] RAW_HW_FAIL_A    = 8'd1;
  localparam logic [7:0] RAW_HW_FAIL_B    = 8'd2;
  localparam logic [7:0] RAW_HW_FAIL_C    = 8'd3;
  localparam logic [7:0] RAW_SIG_FAIL_A   = 8'd4;
  localparam logic [7:0] RAW_OUT_BOUNDS   = 8'd5;
  localparam logic [7:0] RAW_SIG_FAIL_B   = 8'd6;
  localparam logic [7:0] RAW_WRAP_TARGET  = 8'd7;
  localparam logic [7:0] RAW_MIN_CLIPPED  = 8'd8;
  localparam logic [7:0] RAW_RANGE_DONE   = 8'd9;
  localparam logic [7:0] RAW_XTALK_SIGNAL = 8'd12;
  localparam logic [7:0] RAW_MIN_RANGE    = 8'd13;
  localparam logic [7:0] RAW_HW_FAIL_D    = 8'd17;
  localparam logic [7:0] RAW_SYNC_INT     = 8'd18;

  typedef enum logic [3:0] {
    ST_VALID         = 4'd0,
    ST_SIGNAL_FAIL   = 4'd1,
    ST_OUT_OF_BOUNDS = 4'd2,
    ST_HW_FAIL       = 4'd3,
    ST_VALID_NO_WRAP = 4'd4,
    ST_WRAP_TARGET   = 4'd5,
    ST_XTALK_SIGNAL  = 4'd6,
    ST_SYNC_INT      = 4'd7,
    ST_MIN_RANGE     = 4'd8,
    ST_VALID_CLIPPED = 4'd9,
    ST_NONE          = 4'd10
  } status_t;

  // Fields that ride alongside the divide cells unchanged; the bridge updates fallback and sat.
  typedef struct packed {
    logic [15:0] scaled_mm;
    status_t     status;
    logic [15:0] signal_rate;
    logic [15:0] ambient_rate;
    logic        fallback;   // a divisor was zero
    logic        sat;        // request saturates
  } trp_side_t;

  // Per-SPAD rate divide: (total << 16) / effective_spads
  typedef struct packed {
    trp_side_t   side;
    logic [15:0] rem;
    logic [31:0] dvd;        // dividend shifts out the top, quotient fills the bottom
    logic [15:0] spads;
  } trp_rate_t;

  // SPAD request divide: (target << 16) / per_spad, which fits 16 bits when sat is clear
  typedef struct packed {
    trp_side_t   side;
    logic [31:0] rem;
    logic [31:0] per;
    logic [15:0] quo;
  } trp_spad_t;

  function automatic status_t map_status(input logic [7:0] raw, input logic [7:0] stream);
    status_t st;
    case (raw)
      RAW_HW_FAIL_A, RAW_HW_FAIL_B, RAW_HW_FAIL_C, RAW_HW_FAIL_D: st = ST_HW_FAIL;
      RAW_SIG_FAIL_A, RAW_SIG_FAIL_B: st = ST_SIGNAL_FAIL;
      RAW_OUT_BOUNDS:   st = ST_OUT_OF_BOUNDS;
      RAW_WRAP_TARGET:  st = ST_WRAP_TARGET;
      RAW_MIN_CLIPPED:  st = ST_VALID_CLIPPED;
      RAW_RANGE_DONE:   st = (stream == 8'd0) ? ST_VALID_NO_WRAP : ST_VALID;
      RAW_XTALK_SIGNAL: st = ST_XTALK_SIGNAL;
      RAW_MIN_RANGE:    st = ST_MIN_RANGE;
      RAW_SYNC_INT:     st = ST_SYNC_INT;
      default:          st = ST_NONE;
    endcase
    return st;
  endfunction

endpackage

/* hw/rtl/trp_rate_cell.sv */
// One restoring-divide step of the per-SPAD rate divide, with its own stage register.
module trp_rate_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  input  trp_pkg::trp_rate_t up_data,
  output logic               up_ready,
  output logic               dn_valid,
  output trp_pkg::trp_rate_t dn_data,
  input  logic               dn_ready
);
  import trp_pkg::*;

  logic      valid_r, valid_nxt;
  trp_rate_t data_r, data_nxt;
  logic [16:0] shifted;
  logic [16:0] diff;
  logic        take;

  assign up_ready = !valid_r || dn_ready;

  always_comb begin
    shifted  = {up_data.rem, up_data.dvd[31]};
    diff     = shifted - {1'b0, up_data.spads};
    take     = (shifted >= {1'b0, up_data.spads});
    data_nxt = up_data;
    if (take) begin
      data_nxt.rem = diff[15:0];
    end else begin
      data_nxt.rem = shifted[15:0];
    end
    data_nxt.dvd = {up_data.dvd[30:0], take};
    valid_nxt    = up_ready ? up_valid : valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

/* hw/rtl/trp_spad_cell.sv */
// One restoring-divide step of the SPAD request divide, with its own stage register.
module trp_spad_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  input  trp_pkg::trp_spad_t up_data,
  output logic               up_ready,
  output logic               dn_valid,
  output trp_pkg::trp_spad_t dn_data,
  input  logic               dn_ready
);
  import trp_pkg::*;

  logic      valid_r, valid_nxt;
  trp_spad_t data_r, data_nxt;
  logic [32:0] shifted;
  logic [32:0] diff;
  logic        take;

  assign up_ready = !valid_r || dn_ready;

  always_comb begin
    shifted  = {up_data.rem, 1'b0};
    diff     = shifted - {1'b0, up_data.per};
    take     = (shifted >= {1'b0, up_data.per});
    data_nxt = up_data;
    if (take) begin
      data_nxt.rem = diff[31:0];
    end else begin
      data_nxt.rem = shifted[31:0];
    end
    data_nxt.quo = {up_data.quo[14:0], take};
    valid_nxt    = up_ready ? up_valid : valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

/* hw/rtl/tof_range_result_processor_unit.sv */
// Top level: range scaling, status renumbering and SPAD request over a chain of divide cells.
// Path: a record accepted on the input passes through 32 rate divide cells, 1 bridge stage,
//   16 request divide cells and 1 output register before it shows on out_tvalid.
// Throughput: one record per cycle; every cell holds its own valid bit, so bubbles collapse
//   and a stalled output only stops the cells behind it once they fill up.
// Reset (rst_n low, synchronous): all stage valid bits clear, target_rate returns to 2560.
module tof_range_result_processor_unit (
  input  logic        clk,
  input  logic        rst_n,
  // config
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,    // target_rate, 9.7 fixed point
  // input record
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,       // raw_status[7:0], meas_seq[15:8],
                                      // effective_spads[31:16], ambient_rate[47:32],
                                      // signal_rate[63:48], raw_dist_mm[79:64]
  // result
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata       // scaled_mm[15:0], status[19:16],
                                      // required_spads[35:20], signal_rate_out[51:36],
                                      // ambient_rate_out[67:52], zero[71:68]
);
  import trp_pkg::*;

  // ---------------------------------------------------------------------------
  // Target rate register
  // ---------------------------------------------------------------------------
  logic [15:0] target_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= TARGET_RESET;
    end else if (cfg_wr_en) begin
      target_r <= cfg_wr_data;
    end
  end

  // ---------------------------------------------------------------------------
  // Front end: unpack, scale range, renumber status, clip total rate
  // ---------------------------------------------------------------------------
  logic [7:0]  raw_status;
  logic [7:0]  meas_seq;
  logic [15:0] effective_spads;
  logic [15:0] ambient_rate;
  logic [15:0] signal_rate;
  logic [15:0] raw_dist_mm;
  logic [26:0] range_prod;
  logic [26:0] range_sum;
  logic [16:0] rate_sum;
  logic [15:0] total_rate;
  trp_rate_t   front;

  assign raw_status      = in_tdata[7:0];
  assign meas_seq        = in_tdata[15:8];
  assign effective_spads = in_tdata[31:16];
  assign ambient_rate    = in_tdata[47:32];
  assign signal_rate     = in_tdata[63:48];
  assign raw_dist_mm     = in_tdata[79:64];

  always_comb begin
    // gain 2011/2048, round to nearest; the sum never exceeds 27 bits
    range_prod = 27'(raw_dist_mm) * 27'(GAIN_NUM);
    range_sum  = range_prod + GAIN_ROUND;
    rate_sum   = {1'b0, signal_rate} + {1'b0, ambient_rate};
    total_rate = rate_sum[16] ? RATE_CLIP : rate_sum[15:0];

    front.side.scaled_mm    = range_sum[26:11];
    front.side.status       = map_status(raw_status, meas_seq);
    front.side.signal_rate  = signal_rate;
    front.side.ambient_rate = ambient_rate;
    front.side.fallback     = (effective_spads == 16'd0);
    front.side.sat          = 1'b0;
    front.rem               = 16'd0;
    front.dvd               = {total_rate, 16'd0};
    front.spads             = effective_spads;
  end

  // ---------------------------------------------------------------------------
  // Per-SPAD rate divide: one quotient bit per cell
  // ---------------------------------------------------------------------------
  logic      rate_v   [RATE_STEPS+1];
  logic      rate_rdy [RATE_STEPS+1];
  trp_rate_t rate_d   [RATE_STEPS+1];

  assign rate_v[0] = in_tvalid;
  assign rate_d[0] = front;
  assign in_tready = rate_rdy[0];

  for (genvar i = 0; i < RATE_STEPS; i++) begin : g_rate
    trp_rate_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (rate_v[i]),
      .up_data  (rate_d[i]),
      .up_ready (rate_rdy[i]),
      .dn_valid (rate_v[i+1]),
      .dn_data  (rate_d[i+1]),
      .dn_ready (rate_rdy[i+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Bridge stage: flag a zero per-SPAD rate, decide saturation, seed the
  // request divide. Quotient reaches 65536 exactly when target >= per_spad,
  // otherwise the target itself is the first partial remainder.
  // ---------------------------------------------------------------------------
  logic      bridge_v_r, bridge_v_nxt;
  trp_spad_t bridge_r, bridge_nxt;
  logic      bridge_rdy;
  logic [31:0] per_spad;

  logic      spad_v   [SPAD_STEPS+1];
  logic      spad_rdy [SPAD_STEPS+1];
  trp_spad_t spad_d   [SPAD_STEPS+1];

  assign bridge_rdy                = !bridge_v_r || spad_rdy[0];
  assign rate_rdy[RATE_STEPS]      = bridge_rdy;
  assign per_spad                  = rate_d[RATE_STEPS].dvd;

  always_comb begin
    bridge_nxt               = '0;
    bridge_nxt.side          = rate_d[RATE_STEPS].side;
    bridge_nxt.side.fallback = rate_d[RATE_STEPS].side.fallback || (per_spad == 32'd0);
    bridge_nxt.side.sat      = ({16'd0, target_r} >= per_spad);
    bridge_nxt.rem           = {16'd0, target_r};
    bridge_nxt.per           = per_spad;
    bridge_nxt.quo           = 16'd0;
    bridge_v_nxt             = bridge_rdy ? rate_v[RATE_STEPS] : bridge_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bridge_v_r <= 1'b0;
    end else begin
      bridge_v_r <= bridge_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (bridge_rdy && rate_v[RATE_STEPS]) begin
      bridge_r <= bridge_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // SPAD request divide: one quotient bit per cell
  // ---------------------------------------------------------------------------
  assign spad_v[0] = bridge_v_r;
  assign spad_d[0] = bridge_r;

  for (genvar j = 0; j < SPAD_STEPS; j++) begin : g_spad
    trp_spad_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (spad_v[j]),
      .up_data  (spad_d[j]),
      .up_ready (spad_rdy[j]),
      .dn_valid (spad_v[j+1]),
      .dn_data  (spad_d[j+1]),
      .dn_ready (spad_rdy[j+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Output register: pick fallback, saturation or quotient, then hold for the
  // downstream transfer.
  // ---------------------------------------------------------------------------
  logic        out_v_r, out_v_nxt;
  logic [67:0] out_data_r, out_data_nxt;
  logic        out_rdy;
  logic [15:0] req_spads;
  trp_spad_t   last;

  assign last                 = spad_d[SPAD_STEPS];
  assign out_rdy              = !out_v_r || out_tready;
  assign spad_rdy[SPAD_STEPS] = out_rdy;

  always_comb begin
    if (last.side.fallback) begin
      req_spads = SPAD_FALLBACK;
    end else if (last.side.sat) begin
      req_spads = RATE_CLIP;
    end else begin
      req_spads = last.quo;
    end
    out_data_nxt = {last.side.ambient_rate, last.side.signal_rate, req_spads,
                    last.side.status, last.side.scaled_mm};
    out_v_nxt    = out_rdy ? spad_v[SPAD_STEPS] : out_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_rdy && spad_v[SPAD_STEPS]) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {4'd0, out_data_r};

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // An empty output register lets the whole chain advance, so input is open.
  a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_v_r |-> in_tready)
    else $error("input stalled while output register is empty");

  // Every accepted record lands in the first cell.
  a_accept_enters_chain: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> rate_v[1])
    else $error("accepted record missing from first cell");

  // Renumbered status stays within the dense code set.
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (out_data_r[19:16] <= ST_NONE))
    else $error("status out of range");

  // A result leaves the bridge only with a zero-free divisor or the fallback flag.
  a_bridge_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    bridge_v_r |-> (bridge_r.side.fallback || (bridge_r.per != 32'd0)))
    else $error("zero divisor without fallback");

endmodule
